// File: rtl/me_pkg.sv
// Shared constants and register codes for the modular exponentiation block.
// No dependencies.
package me_pkg;

    localparam int FIELD_W   = 32;  // width of message, result and key registers
    localparam int DEF_WIDTH = 32;  // default datapath width
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPONENT = 1'b0,
        REG_MODULUS  = 1'b1
    } t_cfg_idx;

    localparam logic [FIELD_W-1:0] EXPONENT_RST = 32'd1;
    localparam logic [FIELD_W-1:0] MODULUS_RST  = 32'd2;

endpackage

// File: rtl/me_mulmod.sv
// Shift-add-reduce modular multiplier: x * y mod m, one bit of y per cycle.
// Standalone; used by modular_exponentiation. Requires x < m.
module me_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_product
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;

    logic [WIDTH:0]   w_dbl;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH-1:0] w_t1;
    logic [WIDTH-1:0] w_t2;
    logic [WIDTH-1:0] n_acc;

    // acc = 2*acc mod m, then + x mod m when the current bit of y is set
    always_comb begin
        w_dbl = {r_acc, 1'b0};
        if (w_dbl >= {1'b0, r_m}) begin
            w_t1 = WIDTH'(w_dbl - {1'b0, r_m});
        end else begin
            w_t1 = WIDTH'(w_dbl);
        end
        w_sum = {1'b0, w_t1} + {1'b0, r_x};
        if (w_sum >= {1'b0, r_m}) begin
            w_t2 = WIDTH'(w_sum - {1'b0, r_m});
        end else begin
            w_t2 = WIDTH'(w_sum);
        end
        n_acc = r_y[WIDTH-1] ? w_t2 : w_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= {r_y[WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: rtl/modular_exponentiation.sv
// Top level: key registers, square-and-multiply sequencer, output register.
// Depends on me_pkg and me_mulmod.
//
// Each message is returned as message^exponent mod modulus. The message is
// first reduced with one pass of the shared modular multiplier (x = 1), then
// the exponent is scanned from its top bit: one modular squaring per bit and
// one extra multiplication per set bit. A modulus below 2 answers 0.
// s_axis_tready is high only while the block is idle; a finished result waits
// in the output register, and the next message may be taken meanwhile.
// The user must write exponent and modulus only while idle; the block itself
// does not enforce this.
module modular_exponentiation #(
    parameter int WIDTH = me_pkg::DEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // key registers
    input  logic                         i_cfg_wr_en,
    input  logic [me_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [me_pkg::FIELD_W-1:0]   i_cfg_data,
    // message stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [me_pkg::FIELD_W-1:0]   s_axis_tdata,   // [31:0] message
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [me_pkg::FIELD_W-1:0]   m_axis_tdata    // [31:0] result
);

    import me_pkg::*;

    localparam int BIT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } t_state;

    t_state             r_state;
    logic [FIELD_W-1:0] r_exponent;
    logic [FIELD_W-1:0] r_modulus;
    logic [WIDTH-1:0]   r_exp;
    logic [WIDTH-1:0]   r_mod;
    logic [WIDTH-1:0]   r_base;
    logic [WIDTH-1:0]   r_acc;
    logic [BIT_W-1:0]   r_bit;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out;

    logic               w_accept;
    logic [WIDTH-1:0]   w_mod_in;
    logic               w_mm_start;
    logic [WIDTH-1:0]   w_mm_x;
    logic [WIDTH-1:0]   w_mm_y;
    logic [WIDTH-1:0]   w_mm_m;
    logic               w_mm_done;
    logic [WIDTH-1:0]   w_mm_p;
    logic               w_cur_bit;
    logic               w_sq_cur_bit;
    logic               w_out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mod_in      = WIDTH'(r_modulus);
    assign w_cur_bit     = r_exp[r_bit];
    // more exponent bits remain below the current one, so a squaring follows
    assign w_sq_cur_bit  = (r_bit != '0);
    // finished result moves into the output register once it is free
    assign w_out_load    = (r_state == ST_FINISH) && (!r_out_valid || m_axis_tready);

    // start requests and operands for the shared multiplier
    always_comb begin
        w_mm_start = 1'b0;
        w_mm_x     = r_acc;
        w_mm_y     = r_acc;
        w_mm_m     = r_mod;
        case (r_state)
            ST_IDLE: begin
                // message mod m computed as 1 * message mod m
                w_mm_start = w_accept && (w_mod_in >= WIDTH'(2));
                w_mm_x     = WIDTH'(1);
                w_mm_y     = WIDTH'(s_axis_tdata);
                w_mm_m     = w_mod_in;
            end
            ST_BASE: begin
                w_mm_start = w_mm_done;
                w_mm_x     = WIDTH'(1);
                w_mm_y     = WIDTH'(1);
            end
            ST_SQUARE: begin
                if (w_cur_bit) begin
                    w_mm_start = w_mm_done;
                    w_mm_x     = w_mm_p;
                    w_mm_y     = r_base;
                end else begin
                    w_mm_start = w_mm_done && w_sq_cur_bit;
                    w_mm_x     = w_mm_p;
                    w_mm_y     = w_mm_p;
                end
            end
            ST_MULT: begin
                w_mm_start = w_mm_done && w_sq_cur_bit;
                w_mm_x     = w_mm_p;
                w_mm_y     = w_mm_p;
            end
            default: begin
                w_mm_start = 1'b0;
            end
        endcase
    end

    me_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mm_start),
        .i_x       (w_mm_x),
        .i_y       (w_mm_y),
        .i_m       (w_mm_m),
        .o_done    (w_mm_done),
        .o_product (w_mm_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_exponent  <= EXPONENT_RST;
            r_modulus   <= MODULUS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_EXPONENT: r_exponent <= i_cfg_data;
                    REG_MODULUS:  r_modulus  <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_exp <= WIDTH'(r_exponent);
                        r_mod <= w_mod_in;
                        if (w_mod_in >= WIDTH'(2)) begin
                            r_state <= ST_BASE;
                        end else begin
                            r_acc   <= '0;
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_BASE: begin
                    // first squaring of 1 is started here, on the top bit
                    if (w_mm_done) begin
                        r_base  <= w_mm_p;
                        r_acc   <= WIDTH'(1);
                        r_bit   <= BIT_W'(WIDTH - 1);
                        r_state <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (w_mm_done) begin
                        r_acc <= w_mm_p;
                        if (w_cur_bit) begin
                            r_state <= ST_MULT;
                        end else if (w_sq_cur_bit) begin
                            r_bit <= r_bit - BIT_W'(1);
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_MULT: begin
                    if (w_mm_done) begin
                        r_acc <= w_mm_p;
                        if (w_sq_cur_bit) begin
                            r_bit   <= r_bit - BIT_W'(1);
                            r_state <= ST_SQUARE;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (w_out_load) begin
                        r_out   <= FIELD_W'(r_acc);
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// File: dv/tb_modular_exponentiation.sv
// Testbench for modular_exponentiation: drives key writes and message traffic,
// predicts message^exponent mod modulus and checks every result in order.
// Depends on me_pkg and the modular_exponentiation RTL.
module tb_modular_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    import me_pkg::*;

    typedef bit [FIELD_W-1:0] t_word;

    // worst case: 65 multiplier passes, plus handoff
    localparam int ITEM_CYCLES  = (DEF_WIDTH + 1) * (2 * DEF_WIDTH + 1) + 2;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 6000;

    class power_tracker;
        typedef struct {
            t_word message;
            t_word power;
        } t_power;

        t_word  key_exponent = EXPONENT_RST;
        t_word  key_modulus  = MODULUS_RST;
        t_power expected_powers[$];
        int     errors = 0;

        function void set_key(t_cfg_idx idx, t_word value);
            case (idx)
                REG_EXPONENT: key_exponent = value;
                REG_MODULUS:  key_modulus  = value;
                default: ;
            endcase
        endfunction

        // left-to-right square-and-multiply; 64-bit products cannot overflow
        function t_word predict_power(t_word message);
            bit [63:0] m;
            bit [63:0] base;
            bit [63:0] acc;
            if (key_modulus < 2)
                return '0;
            m    = key_modulus;
            base = message % m;
            acc  = 1 % m;
            for (int i = FIELD_W - 1; i >= 0; i--) begin
                acc = (acc * acc) % m;
                if (key_exponent[i])
                    acc = (acc * base) % m;
            end
            return acc[FIELD_W-1:0];
        endfunction

        function void note_message(t_word message);
            t_power item;
            item.message = message;
            item.power   = predict_power(message);
            expected_powers.push_back(item);
        endfunction

        function void check_result(t_word actual);
            t_power item;
            if (expected_powers.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h with nothing pending", actual);
                return;
            end
            item = expected_powers.pop_front();
            if (actual !== item.power) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: message %h expected %h actual %h",
                             item.message, item.power, actual);
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FIELD_W-1:0]   i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [FIELD_W-1:0]   s_axis_tdata;   // [31:0] message
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [FIELD_W-1:0]   m_axis_tdata;   // [31:0] result

    power_tracker powers = new();
    bit           hold_req = 1'b0;

    modular_exponentiation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // key registers may only change with nothing in flight
    task automatic wait_idle();
        while (powers.pending() != 0 || !s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic write_keys(input t_word exp_val, input t_word mod_val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_EXPONENT;
        i_cfg_data  <= exp_val;
        @(posedge i_clk);
        i_cfg_index <= REG_MODULUS;
        i_cfg_data  <= mod_val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        powers.set_key(REG_EXPONENT, exp_val);
        powers.set_key(REG_MODULUS, mod_val);
    endtask

    task automatic send_message(input t_word message);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= message;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        powers.note_message(message);
    endtask

    // bursts of back-to-back offers separated by gaps of mixed length
    task automatic send_run(input t_word msgs[$]);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 8);
        for (int k = 0; k < msgs.size(); k++) begin
            send_message(msgs[k]);
            burst_left--;
            if (k == msgs.size() - 1) begin
                s_axis_tvalid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 3);
                    6, 7, 8:          gap = $urandom_range(4, 40);
                    default:          gap = $urandom_range(100, ITEM_CYCLES + 200);
                endcase
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic run_phase(input t_word exp_val, input t_word mod_val, input t_word msgs[$]);
        wait_idle();
        write_keys(exp_val, mod_val);
        send_run(msgs);
    endtask

    function automatic t_word pick_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'd65537;
            3:       return 32'd3;
            4, 5:    return $urandom_range(1, 32'hFFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word pick_modulus();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return '1;
            4:       return $urandom_range(3, 1000);
            5, 6:    return $urandom | 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word pick_message(t_word mod_val);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mod_val - 1;
            2:       return mod_val;
            3:       return (mod_val == 0) ? t_word'($urandom) : t_word'($urandom % mod_val);
            default: return $urandom;
        endcase
    endfunction

    // result side: own stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_taken;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                powers.check_result(m_axis_tdata);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("modular_exponentiation test failed");
        $finish;
    end

    initial begin
        t_word msgs[$];
        t_word exp_val;
        t_word mod_val;
        int    n;
        int    sent_random;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= REG_EXPONENT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key: exponent 1, modulus 2
        msgs = {32'h0, 32'h1, 32'hFFFF_FFFF, 32'h2};
        send_run(msgs);

        // exponent zero gives 1
        msgs = {32'h0, 32'h0001_2345, 32'hFFFF_FFFF};
        run_phase('0, '1, msgs);

        // all-ones exponent: longest sequence
        msgs = {32'hFFFF_FFFE, 32'h0, 32'h2};
        run_phase('1, '1, msgs);
        msgs = {32'hAAAA_AAAA, 32'h5555_5555};
        run_phase('1, 32'hFFFF_FFFB, msgs);

        // modulus one and modulus zero both answer 0
        msgs = {32'h0, 32'hFFFF_FFFF};
        run_phase(32'h1234_5679, 32'd1, msgs);
        msgs = {32'h7, 32'hFFFF_FFFF};
        run_phase(32'd65537, 32'd0, msgs);

        // message at and above the modulus is reduced first
        msgs = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};
        run_phase(32'd65537, 32'h8000_0000, msgs);

        // small textbook key pair: encrypt then decrypt
        msgs = {32'd65};
        run_phase(32'd17, 32'd3233, msgs);
        msgs = {32'd2790};
        run_phase(32'd2753, 32'd3233, msgs);

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            exp_val = pick_exponent();
            mod_val = pick_modulus();
            if (sent_random == 0) begin
                // long run with a normal key while the result side holds off
                exp_val = 32'd65537;
                mod_val = $urandom | 32'h8000_0000;
                n       = 24;
            end else begin
                n = $urandom_range(6, 30);
            end
            if (n > RANDOM_ITEMS - sent_random)
                n = RANDOM_ITEMS - sent_random;
            msgs.delete();
            for (int k = 0; k < n; k++)
                msgs.push_back(pick_message(mod_val));
            wait_idle();
            write_keys(exp_val, mod_val);
            if (sent_random == 0)
                hold_req = 1'b1;
            send_run(msgs);
            sent_random += n;
        end

        wait_idle();
        repeat (ITEM_CYCLES + 100) @(posedge i_clk);
        if (powers.errors == 0 && powers.pending() == 0)
            $display("modular_exponentiation test passed");
        else
            $display("modular_exponentiation test failed");
        $finish;
    end

endmodule
